### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/iptl_pkg.sv
package iptl_pkg;

    localparam int IP_W   = 32;
    localparam int PLEN_W = 6;
    localparam int ZONE_W = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ALLOC,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        logic              func;
        logic [IP_W-1:0]   ip_address;
        logic [PLEN_W-1:0] prefix_length;
        logic [ZONE_W-1:0] zone_id;
    } cmd_t;

    typedef struct packed {
        logic [ZONE_W-1:0] found_zone;
        logic              status;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } walk_stat_t;

endpackage

### src/iptl_ram.sv
module iptl_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/iptl_walk.sv
module iptl_walk #(
    parameter int NODE_COUNT   = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  iptl_pkg::cmd_t      cmd,
    input  logic                take,
    output iptl_pkg::walk_stat_t stat,
    output iptl_pkg::res_t      res
);

    import iptl_pkg::*;

    localparam int NIDX  = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int LVL_W = $clog2(ADDRESS_BITS + 1);
    localparam int ENT_W = ZONE_W + 2 * NIDX;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [NIDX-1:0]   zero_child;
        logic [NIDX-1:0]   one_child;
    } entry_t;

    walk_state_t             state_reg, state_next;
    logic [NIDX-1:0]         node_reg, node_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [LVL_W-1:0]        tgt_reg, tgt_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic                    func_reg, func_next;
    logic [ZONE_W-1:0]       zone_reg, zone_next;
    logic                    fresh_reg, fresh_next;
    logic [ZONE_W-1:0]       found_reg, found_next;
    logic                    status_reg, status_next;
    logic [CNT_W-1:0]        nodes_used_reg, nodes_used_next;
    entry_t                  root_reg, root_next;

    logic                    wr_en;
    logic [NIDX-1:0]         wr_addr;
    entry_t                  wr_data;
    logic                    rd_en;
    logic [NIDX-1:0]         rd_addr;
    logic [ENT_W-1:0]        rd_data;

    entry_t                  cur;
    entry_t                  upd;
    logic                    dir;
    logic [NIDX-1:0]         child;
    logic [NIDX-1:0]         new_node;

    iptl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nodes_used_reg <= CNT_W'(1);
            root_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            root_reg       <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        lvl_reg    <= lvl_next;
        tgt_reg    <= tgt_next;
        addr_reg   <= addr_next;
        func_reg   <= func_next;
        zone_reg   <= zone_next;
        fresh_reg  <= fresh_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    // Node entry under evaluation: a just-allocated node is known empty,
    // the root lives in flops, every other node comes from the RAM.
    always_comb
    begin
        if (fresh_reg)
        begin
            cur = '0;
        end
        else if (node_reg == '0)
        begin
            cur = root_reg;
        end
        else
        begin
            cur = entry_t'(rd_data);
        end
        dir      = addr_reg[ADDRESS_BITS-1];
        child    = dir ? cur.one_child : cur.zero_child;
        new_node = nodes_used_reg[NIDX-1:0];
        upd      = cur;
        if (dir)
        begin
            upd.one_child = new_node;
        end
        else
        begin
            upd.zero_child = new_node;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        lvl_next        = lvl_reg;
        tgt_next        = tgt_reg;
        addr_next       = addr_reg;
        func_next       = func_reg;
        zone_next       = zone_reg;
        fresh_next      = fresh_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        nodes_used_next = nodes_used_reg;
        root_next       = root_reg;
        wr_en           = 1'b0;
        wr_addr         = node_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = child;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    node_next   = '0;
                    lvl_next    = '0;
                    addr_next   = ADDRESS_BITS'(cmd.ip_address);
                    func_next   = cmd.func;
                    zone_next   = cmd.zone_id;
                    fresh_next  = 1'b0;
                    found_next  = '0;
                    status_next = STATUS_OK;
                    if (cmd.func == FUNC_LOOKUP || int'(cmd.prefix_length) > ADDRESS_BITS)
                    begin
                        tgt_next = LVL_W'(ADDRESS_BITS);
                    end
                    else
                    begin
                        tgt_next = LVL_W'(cmd.prefix_length);
                    end
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (func_reg == FUNC_LOOKUP)
                begin
                    if (cur.zone != '0)
                    begin
                        found_next = cur.zone;
                    end
                    priority if (lvl_reg == tgt_reg || child == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        node_next  = child;
                        lvl_next   = LVL_W'(lvl_reg + 1'b1);
                        addr_next  = addr_reg << 1;
                        fresh_next = 1'b0;
                    end
                end
                else
                begin
                    priority if (lvl_reg == tgt_reg)
                    begin
                        // End of prefix: store the zone, keep the children.
                        if (node_reg == '0)
                        begin
                            root_next.zone = zone_reg;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = cur;
                            wr_data.zone = zone_reg;
                        end
                        state_next = ST_DONE;
                    end
                    else if (child != '0)
                    begin
                        rd_en      = 1'b1;
                        node_next  = child;
                        lvl_next   = LVL_W'(lvl_reg + 1'b1);
                        addr_next  = addr_reg << 1;
                        fresh_next = 1'b0;
                    end
                    else if (nodes_used_reg >= CNT_W'(NODE_COUNT))
                    begin
                        status_next = STATUS_FULL;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // Link the new node into its parent, clear it next cycle.
                        if (node_reg == '0)
                        begin
                            root_next = upd;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = upd;
                        end
                        nodes_used_next = CNT_W'(nodes_used_reg + 1'b1);
                        node_next       = new_node;
                        lvl_next        = LVL_W'(lvl_reg + 1'b1);
                        addr_next       = addr_reg << 1;
                        state_next      = ST_ALLOC;
                    end
                end
            end

            ST_ALLOC:
            begin
                wr_en      = 1'b1;
                wr_addr    = node_reg;
                wr_data    = '0;
                fresh_next = 1'b1;
                state_next = ST_WALK;
            end

            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.done      = (state_reg == ST_DONE);
    assign res.found_zone = found_reg;
    assign res.status     = status_reg;

endmodule

### src/ipv4_prefix_trie_lookup_top.sv
// IPv4 longest-prefix-match trie. A word with func = 0 inserts the prefix
// (ip_address, prefix_length) with zone_id, allocating trie nodes from a pool of
// NODE_COUNT entries; status = 1 reports that the pool ran out (nodes allocated
// so far stay). A word with func = 1 looks up ip_address and returns the zone of
// the longest stored prefix, or 0. Each word walks the trie one level at a time
// from the root (up to ADDRESS_BITS + 1 levels; the root is held in flops, other
// stored nodes are read from the node RAM), an insert clears each node it allocates
// in a separate step, and the result is then handed to the output register. The
// trie walk handles one word at a time; the next word is taken as soon as the walk
// has passed its result on. After reset the trie is empty and usable at once.
`include "assert_macros.svh"

module ipv4_prefix_trie_lookup_top #(
    parameter int NODE_COUNT   = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [iptl_pkg::IP_W-1:0]          ip_address,
    input  logic [iptl_pkg::PLEN_W-1:0]        prefix_length,
    input  logic [iptl_pkg::ZONE_W-1:0]        zone_id,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [iptl_pkg::ZONE_W-1:0]        found_zone,
    output logic                               status
);

    import iptl_pkg::*;

    cmd_t              cmd;
    res_t              res;
    walk_stat_t        stat;
    logic              start;
    logic              load;
    logic              out_valid_reg, out_valid_next;
    logic [ZONE_W-1:0] found_zone_reg;
    logic              status_reg;

    assign cmd.func          = func;
    assign cmd.ip_address    = ip_address;
    assign cmd.prefix_length = prefix_length;
    assign cmd.zone_id       = zone_id;

    assign in_stall = !stat.idle;
    assign start    = in_valid && stat.idle;

    // Move the result into the output register when the slot is free or draining.
    assign load = stat.done && (!out_valid_reg || !out_stall);

    iptl_walk #(
        .NODE_COUNT   (NODE_COUNT),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .take  (load),
        .stat  (stat),
        .res   (res)
    );

    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_zone_reg <= res.found_zone;
            status_reg     <= res.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found_zone = found_zone_reg;
    assign status     = status_reg;

    `ASSERT_PROP(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "walk idle after accepting a word")
    `ASSERT_PROP(a_load_sets_valid, load |=> out_valid, "loaded result not presented")
    `ASSERT_NEVER(a_done_while_idle, stat.done && stat.idle, "walk reports idle and done together")
    `ASSERT_NEVER(a_full_has_no_zone, out_valid && status == STATUS_FULL && found_zone != '0, "pool-full result carries a zone")

endmodule
